[rtl/core/mlt_pkg.sv]
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types, constants and the preset address table of the MAC learning
// table.
// ----------------------------------------------------------------------------
package mlt_pkg;

  // field widths
  localparam int unsigned MacW    = 48;
  localparam int unsigned PortW   = 5;
  localparam int unsigned StatusW = 2;

  // default table capacity and number of preset slots
  localparam int unsigned DefaultTableDepth = 16;
  localparam int unsigned PresetCount       = 4;

  // learn outcome codes
  typedef enum logic [StatusW-1:0] {
    LearnKnown = 2'd0,
    LearnAdded = 2'd1,
    LearnFull  = 2'd2
  } learn_status_e;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic en;
  } scan_ctl_t;

  // results of one sweep
  typedef struct packed {
    logic dest_hit;
    logic src_hit;
  } scan_res_t;

  // fixed addresses held in the first four slots
  function automatic logic [MacW-1:0] preset_mac(input logic [1:0] slot);
    logic [MacW-1:0] mac;
    unique case (slot)
      2'd0:    mac = 48'hFDF0_B4E1_0000;
      2'd1:    mac = 48'h147B_F0E1_0001;
      2'd2:    mac = 48'h792B_B4E1_C300;
      default: mac = 48'hC2F0_B4E1_BE00;
    endcase
    return mac;
  endfunction

endpackage

[rtl/core/mac_learning_table_unit.sv]
// ----------------------------------------------------------------------------
// mac_learning_table_unit
// Ethernet MAC learning table: destination lookup and source learning.
// ----------------------------------------------------------------------------
// Usage:
//   An item (dest_mac_i, src_mac_i) is taken at a rising edge with start_i
//   high and busy_o low. busy_o then stays high while the item is handled.
//   The block sweeps the valid slots once through a single memory read port,
//   comparing each word against both addresses, then learns the source.
//   The result (out_port_o, learn_status_o) appears for exactly one cycle
//   with done_o high; busy_o is already low in that cycle, so the next item
//   may be started alongside the result strobe.
//   The sweep makes one read a cycle, so the time per item grows with the
//   entry count; busy_o holds off the next item until the result strobe.
//   Reset clears the entry count to the four preset slots, which come from
//   constants, so no clearing pass is needed and an item may start at once.
//   The receiver cannot stall: done_o is a strobe and is never held.
// ----------------------------------------------------------------------------
module mac_learning_table_unit #(
  parameter int unsigned TableDepth = mlt_pkg::DefaultTableDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [mlt_pkg::MacW-1:0]    dest_mac_i,
  input  logic [mlt_pkg::MacW-1:0]    src_mac_i,
  output logic                        done_o,
  output logic [mlt_pkg::PortW-1:0]   out_port_o,
  output logic [mlt_pkg::StatusW-1:0] learn_status_o
);

  localparam int unsigned AddrW  = $clog2(TableDepth);
  localparam int unsigned CountW = $clog2(TableDepth + 1);
  localparam int unsigned SumW   = (AddrW + 1 > mlt_pkg::PortW) ? AddrW + 1 : mlt_pkg::PortW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StLearn
  } state_e;

  state_e                        state_q;
  logic [CountW-1:0]             count_q;
  logic [AddrW-1:0]              idx_q;
  logic                          rd_vld_q;
  logic [AddrW-1:0]              rd_slot_q;
  logic [mlt_pkg::MacW-1:0]      dest_q;
  logic [mlt_pkg::MacW-1:0]      src_q;
  logic                          done_q;
  logic [mlt_pkg::PortW-1:0]     port_q;
  logic [mlt_pkg::StatusW-1:0]   status_q;

  mlt_pkg::scan_ctl_t            scan_ctl;
  mlt_pkg::scan_res_t            scan_res;
  logic [mlt_pkg::MacW-1:0]      rd_word;
  logic [AddrW-1:0]              dest_slot;
  logic                          last_idx;
  logic                          has_room;
  logic                          learn_we;
  logic [SumW-1:0]               port_sum;

  // sweep control
  assign last_idx = (CountW'(idx_q) == (count_q - CountW'(1)));
  assign has_room = (count_q < CountW'(TableDepth));
  assign learn_we = (state_q == StLearn) && !scan_res.src_hit && has_room;

  assign scan_ctl.clear = (state_q == StIdle);
  assign scan_ctl.en    = rd_vld_q;

  assign port_sum = SumW'(dest_slot) + SumW'(1);

  // address store
  mlt_store #(
    .TableDepth(TableDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (learn_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(src_q),
    .raddr_i(idx_q),
    .rdata_o(rd_word)
  );

  // shared compare unit
  mlt_match #(
    .TableDepth(TableDepth)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .word_i     (rd_word),
    .slot_i     (rd_slot_q),
    .dest_mac_i (dest_q),
    .src_mac_i  (src_q),
    .res_o      (scan_res),
    .dest_slot_o(dest_slot)
  );

  // sequencer, entry count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= CountW'(mlt_pkg::PresetCount);
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            idx_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          rd_vld_q <= 1'b1;
          if (last_idx) begin
            state_q <= StDrain;
          end else begin
            idx_q <= idx_q + AddrW'(1);
          end
        end
        StDrain: begin
          state_q <= StLearn;
        end
        StLearn: begin
          done_q  <= 1'b1;
          state_q <= StIdle;
          if (learn_we) begin
            count_q <= count_q + CountW'(1);
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // item capture, read slot tracking and result payload
  always_ff @(posedge clk_i) begin
    rd_slot_q <= idx_q;
    if ((state_q == StIdle) && start_i) begin
      dest_q <= dest_mac_i;
      src_q  <= src_mac_i;
    end
    if (state_q == StLearn) begin
      port_q <= scan_res.dest_hit ? port_sum[mlt_pkg::PortW-1:0] : '0;
      priority if (scan_res.src_hit) begin
        status_q <= mlt_pkg::LearnKnown;
      end else if (has_room) begin
        status_q <= mlt_pkg::LearnAdded;
      end else begin
        status_q <= mlt_pkg::LearnFull;
      end
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign done_o         = done_q;
  assign out_port_o     = port_q;
  assign learn_status_o = status_q;

endmodule

[rtl/core/mlt_store.sv]
// ----------------------------------------------------------------------------
// mlt_store
// Address store: learned slots in a memory with one write and one read port,
// preset slots supplied from constants. Read data is registered.
// ----------------------------------------------------------------------------
module mlt_store #(
  parameter int unsigned TableDepth = mlt_pkg::DefaultTableDepth,
  localparam int unsigned AddrW     = $clog2(TableDepth)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic [mlt_pkg::MacW-1:0] wdata_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic [mlt_pkg::MacW-1:0] rdata_o
);

  logic [mlt_pkg::MacW-1:0] mem [TableDepth];
  logic [mlt_pkg::MacW-1:0] mem_q;
  logic [mlt_pkg::MacW-1:0] preset_q;
  logic                     preset_sel_q;

  // write port, only ever slots beyond the presets
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, presets taken from the constant table
  // one spare bit so the preset bound fits in any table of three slots or more
  always_ff @(posedge clk_i) begin
    mem_q        <= mem[raddr_i];
    preset_q     <= mlt_pkg::preset_mac(raddr_i[1:0]);
    preset_sel_q <= ({1'b0, raddr_i} < (AddrW + 1)'(mlt_pkg::PresetCount));
  end

  assign rdata_o = preset_sel_q ? preset_q : mem_q;

endmodule

[rtl/core/mlt_match.sv]
// ----------------------------------------------------------------------------
// mlt_match
// Compare unit: checks each word read from the store against the item's
// destination and source and keeps the first destination hit.
// ----------------------------------------------------------------------------
module mlt_match #(
  parameter int unsigned TableDepth = mlt_pkg::DefaultTableDepth,
  localparam int unsigned AddrW     = $clog2(TableDepth)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mlt_pkg::scan_ctl_t       ctl_i,
  input  logic [mlt_pkg::MacW-1:0] word_i,
  input  logic [AddrW-1:0]         slot_i,
  input  logic [mlt_pkg::MacW-1:0] dest_mac_i,
  input  logic [mlt_pkg::MacW-1:0] src_mac_i,
  output mlt_pkg::scan_res_t       res_o,
  output logic [AddrW-1:0]         dest_slot_o
);

  mlt_pkg::scan_res_t res_q;
  logic [AddrW-1:0]   dest_slot_q;

  // hit flags, held once set until the next clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (ctl_i.clear) begin
      res_q <= '0;
    end else if (ctl_i.en) begin
      if (word_i == dest_mac_i) begin
        res_q.dest_hit <= 1'b1;
      end
      if (word_i == src_mac_i) begin
        res_q.src_hit <= 1'b1;
      end
    end
  end

  // slot of the first destination match
  always_ff @(posedge clk_i) begin
    if (ctl_i.en && !res_q.dest_hit && (word_i == dest_mac_i)) begin
      dest_slot_q <= slot_i;
    end
  end

  assign res_o       = res_q;
  assign dest_slot_o = dest_slot_q;

endmodule
